FILE: hw/rtl/olir_pkg.sv
// ----------------------------------------------------------------------------
// olir_pkg: shared definitions for the ordered list
// Command codes, result status codes, fixed field widths and defaults.
// ----------------------------------------------------------------------------
package olir_pkg;

  localparam int CAPACITY_DEFAULT    = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  localparam int CmdW   = 2;
  localparam int ItemW  = 32;
  localparam int CountW = 5;

  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_LIST   = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5
  } status_t;

endpackage

FILE: hw/rtl/olir_mem.sv
// ----------------------------------------------------------------------------
// olir_mem: entry storage
// Single write port, single read port, read data registered.
// The read data register holds its value while no read is issued.
// ----------------------------------------------------------------------------
module olir_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/olir_seq.sv
// ----------------------------------------------------------------------------
// olir_seq: list sequencer
// Runs insert, remove (scan and close the gap in one pass) and list walks
// against the entry memory, and owns the result register.
// ----------------------------------------------------------------------------
module olir_seq #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       req_valid,
  output logic                                       req_stall,
  input  logic [olir_pkg::CmdW-1:0]                  command,
  input  logic signed [olir_pkg::ItemW-1:0]          operand_value,
  output logic                                       rsp_valid,
  input  logic                                       rsp_stall,
  output olir_pkg::status_t                          status,
  output logic signed [olir_pkg::ItemW-1:0]          item_value,
  output logic                                       last_of_run,
  output logic signed [olir_pkg::ItemW-1:0]          head_value,
  output logic                                       is_empty,
  output logic [olir_pkg::CountW-1:0]                entry_count,
  output logic                                       mem_wr_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
  output logic [VALUE_WIDTH-1:0]                     mem_wr_data,
  output logic                                       mem_rd_en,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
  input  logic [VALUE_WIDTH-1:0]                     mem_rd_data
);
  import olir_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int ExtW  = (VALUE_WIDTH > ItemW) ? VALUE_WIDTH : ItemW;

  typedef enum logic [1:0] {S_IDLE, S_REM, S_LIST, S_EMIT} state_t;

  state_t                 state;
  logic [CntW-1:0]        count;
  logic [VALUE_WIDTH-1:0] head;
  logic [VALUE_WIDTH-1:0] val;
  logic [AddrW-1:0]       dk;       // index of the entry now in the read register
  logic                   found;
  logic [VALUE_WIDTH-1:0] gone;
  status_t                res_status;
  logic [ItemW-1:0]       res_item;

  logic [ExtW-1:0]        opnd_ext;
  logic [VALUE_WIDTH-1:0] val_in;
  logic                   slot_free;
  logic                   at_last;
  logic                   hit;
  logic                   full;
  logic                   cnt_zero;

  function automatic logic [ItemW-1:0] to_item(input logic [VALUE_WIDTH-1:0] x);
    logic [ExtW-1:0] e;
    e = ExtW'(x);
    return e[ItemW-1:0];
  endfunction

  assign opnd_ext  = ExtW'($unsigned(operand_value));
  assign val_in    = opnd_ext[VALUE_WIDTH-1:0];
  assign slot_free = !rsp_valid || !rsp_stall;
  assign at_last   = (CntW'(dk) + CntW'(1)) == count;
  assign hit       = !found && (mem_rd_data == val);
  assign full      = (count == CntW'(CAPACITY));
  assign cnt_zero  = (count == '0);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = AddrW'(count);
    mem_wr_data = val_in;
    mem_rd_en   = 1'b0;
    mem_rd_addr = dk + AddrW'(1);
    unique case (state)
      S_IDLE: begin
        mem_rd_addr = '0;
        if (req_valid) begin
          if (command == CMD_INSERT && !full) begin
            mem_wr_en = 1'b1;
          end
          if ((command == CMD_REMOVE || command == CMD_LIST) && !cnt_zero) begin
            mem_rd_en = 1'b1;
          end
        end
      end
      S_REM: begin
        mem_rd_en = !at_last;
        // entries behind the match move down by one
        if (found) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = dk - AddrW'(1);
          mem_wr_data = mem_rd_data;
        end
      end
      S_LIST: begin
        mem_rd_en = slot_free && !at_last;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            val   <= val_in;
            dk    <= '0;
            found <= 1'b0;
            case (command)
              CMD_INSERT: begin
                res_item <= to_item(val_in);
                state    <= S_EMIT;
                if (full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_INSERTED;
                  count      <= count + CntW'(1);
                  if (cnt_zero) begin
                    head <= val_in;
                  end
                end
              end
              CMD_REMOVE: begin
                if (cnt_zero) begin
                  res_status <= ST_EMPTY;
                  res_item   <= to_item(val_in);
                  state      <= S_EMIT;
                end else begin
                  state <= S_REM;
                end
              end
              CMD_LIST: begin
                if (cnt_zero) begin
                  res_status <= ST_EMPTY;
                  res_item   <= '0;
                  state      <= S_EMIT;
                end else begin
                  state <= S_LIST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_REM: begin
          if (hit) begin
            found <= 1'b1;
            gone  <= mem_rd_data;
          end
          // removing the head: the next entry becomes the head
          if (found && dk == AddrW'(1)) begin
            head <= mem_rd_data;
          end
          if (at_last) begin
            state <= S_EMIT;
            if (found || hit) begin
              res_status <= ST_REMOVED;
              res_item   <= to_item(found ? gone : mem_rd_data);
              count      <= count - CntW'(1);
            end else begin
              res_status <= ST_NOT_FOUND;
              res_item   <= to_item(val);
            end
          end else begin
            dk <= dk + AddrW'(1);
          end
        end
        S_LIST: begin
          if (slot_free) begin
            rsp_valid   <= 1'b1;
            status      <= ST_LISTED;
            item_value  <= to_item(mem_rd_data);
            last_of_run <= at_last;
            head_value  <= to_item(head);
            is_empty    <= 1'b0;
            entry_count <= CountW'(count);
            if (at_last) begin
              state <= S_IDLE;
            end else begin
              dk <= dk + AddrW'(1);
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            rsp_valid   <= 1'b1;
            status      <= res_status;
            item_value  <= res_item;
            last_of_run <= 1'b1;
            head_value  <= cnt_zero ? '0 : to_item(head);
            is_empty    <= cnt_zero;
            entry_count <= CountW'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/ordered_list_insert_remove.sv
// Sequence: insert writes the tail entry unless full, then reports from S_EMIT; remove
// scans the stored entries in S_REM, then reports from S_EMIT; list emits one entry per
// cycle from S_LIST while results are taken. One item at a time; remove and list walk
// the entry memory one read per cycle, list only while results are taken. An unused command code is ignored.
// Reset: rst clears the entry count, sequencer state and result valid; entries are not
// cleared, they are only read below the count.
// ----------------------------------------------------------------------------
// ordered_list_insert_remove: bounded ordered list
// Insert at tail, remove first match with order kept, list head to tail.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove #(
  parameter int CAPACITY    = olir_pkg::CAPACITY_DEFAULT,
  parameter int VALUE_WIDTH = olir_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [olir_pkg::CmdW-1:0]         command,
  input  logic signed [olir_pkg::ItemW-1:0] operand_value,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output olir_pkg::status_t                 status,
  output logic signed [olir_pkg::ItemW-1:0] item_value,
  output logic                              last_of_run,
  output logic signed [olir_pkg::ItemW-1:0] head_value,
  output logic                              is_empty,
  output logic [olir_pkg::CountW-1:0]       entry_count
);
  import olir_pkg::*;

  localparam int AddrW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                   mem_wr_en;
  logic [AddrW-1:0]       mem_wr_addr;
  logic [VALUE_WIDTH-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [AddrW-1:0]       mem_rd_addr;
  logic [VALUE_WIDTH-1:0] mem_rd_data;

  olir_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  olir_seq #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .command       (command),
    .operand_value (operand_value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .item_value    (item_value),
    .last_of_run   (last_of_run),
    .head_value    (head_value),
    .is_empty      (is_empty),
    .entry_count   (entry_count),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall &&
    (command == CMD_INSERT || command == CMD_REMOVE || command == CMD_LIST)
    |=> req_stall)
    else $error("valid command accepted but sequencer stayed idle");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> entry_count == '0 && head_value == '0)
    else $error("empty result with nonzero count or head");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_INSERTED |-> !is_empty)
    else $error("insert result reports empty list");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_LISTED |-> last_of_run)
    else $error("single result not marked last");
`endif

endmodule
